>>> rtl/motor_current_power_limiter_assert.svh
// ----------------------------------------------------------------------------
// motor_current_power_limiter_assert.svh
// Assertion macros for the motor current power limiter.
// ----------------------------------------------------------------------------
`ifndef MOTOR_CURRENT_POWER_LIMITER_ASSERT_SVH
`define MOTOR_CURRENT_POWER_LIMITER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define PLIM_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plim check failed");
// next-cycle implication
`define PLIM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plim check failed");
`else
`define PLIM_ASSERT_IMPLY(lbl, ante, cons)
`define PLIM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/plim_pkg.sv
// ----------------------------------------------------------------------------
// plim_pkg
// Types and constants shared by the power limiter modules.
// ----------------------------------------------------------------------------
`default_nettype none
package plim_pkg;

    localparam int FIELDS = 4;
    localparam logic [15:0] BUFFER_FLOOR = 16'd80;   // 5 J in 1/16 J
    localparam logic [17:0] ALLOW_MAX = 18'h3FFFF;

    typedef enum logic [2:0] {
        REG_WARNING_BUFFER   = 3'd0,
        REG_WARNING_POWER    = 3'd1,
        REG_POWER_CEILING    = 3'd2,
        REG_BUFFER_ALLOWANCE = 3'd3,
        REG_POWER_ALLOWANCE  = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic               enable;
        logic        [15:0] power;
        logic        [15:0] energy_buffer;
        logic signed [15:0] current_0;
        logic signed [15:0] current_1;
        logic signed [15:0] current_2;
        logic signed [15:0] current_3;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] limited_0;
        logic signed [15:0] limited_1;
        logic signed [15:0] limited_2;
        logic signed [15:0] limited_3;
    } out_word_t;

    // travels beside the allowance divider
    typedef struct packed {
        logic                    en;
        logic [16:0]             base;
        logic [17:0]             sum;
        logic [FIELDS-1:0]       neg;
        logic [FIELDS-1:0][15:0] mag;
    } alw_side_t;

    // travels beside each lane divider
    typedef struct packed {
        logic        neg;
        logic        scale;
        logic [15:0] mag;
    } lane_side_t;

endpackage
`default_nettype wire

>>> rtl/plim_div.sv
// ----------------------------------------------------------------------------
// plim_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none
module plim_div #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 16,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              adv,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic [NUM_W-1:0]  quo,
    output logic [SIDE_W-1:0] side_out
);

    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [NUM_W-1:0]  nq_reg   [NUM_W];   // numerator shifts out, quotient in
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [DEN_W-1:0]  rem_in;
        logic [NUM_W-1:0]  nq_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_c;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              ge;
        logic [DEN_W-1:0]  rem_next;
        logic [NUM_W-1:0]  nq_next;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
            assign side_c = side_in;
        end else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign nq_in  = nq_reg[s-1];
            assign den_in = den_reg[s-1];
            assign side_c = side_reg[s-1];
        end

        assign trial    = {rem_in, nq_in[NUM_W-1]};
        assign diff     = trial - {1'b0, den_in};
        assign ge       = (trial >= {1'b0, den_in});
        assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign nq_next  = {nq_in[NUM_W-2:0], ge};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s]  <= rem_next;
                nq_reg[s]   <= nq_next;
                den_reg[s]  <= den_in;
                side_reg[s] <= side_c;
            end
        end
    end

    assign quo      = nq_reg[NUM_W-1];
    assign side_out = side_reg[NUM_W-1];

endmodule
`default_nettype wire

>>> rtl/motor_current_power_limiter.sv
// ----------------------------------------------------------------------------
// motor_current_power_limiter
// Scales motor current commands so their absolute sum stays within an
// allowance set by buffer energy and measured power.
// ----------------------------------------------------------------------------
// Channel   Signals                                   Direction
// sample    sample_valid / sample_ready / sample      in  (in_word_t)
// result    result_valid / result_ready / result      out (out_word_t)
// cfg       cfg_valid / cfg_ready / cfg_index/cfg_data in (register write)
//
// Fully pipelined: one word per cycle while sample_ready is high.
// The pipeline holds the 32-stage allowance divider followed by the
// 34-stage per-lane scaling dividers.
// Reset clears the valid pipeline and loads the register defaults.
// A result that is not taken parks in the output register; one more word
// lands in a skid register, after which sample_ready drops and the whole
// pipeline holds until the result side drains.
// ----------------------------------------------------------------------------
`default_nettype none
`include "motor_current_power_limiter_assert.svh"
module motor_current_power_limiter
    import plim_pkg::*;
#(
    parameter int MOTORS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  in_word_t    sample,
    output logic        result_valid,
    input  logic        result_ready,
    output out_word_t   result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int LANES   = (MOTORS > FIELDS) ? FIELDS : MOTORS;
    localparam int ALW_W   = 32;            // allowance numerator bits
    localparam int LANE_W  = 34;            // lane numerator bits
    localparam int NV      = 3 + ALW_W + 2 + LANE_W;
    localparam int ALW_SW  = $bits(alw_side_t);
    localparam int LANE_SW = $bits(lane_side_t);

    // ---------------- configuration ----------------
    logic [11:0] wb_reg;
    logic [15:0] wp_reg, pc_reg, ba_reg, pa_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_reg <= 12'd960;
            wp_reg <= 16'd640;
            pc_reg <= 16'd1280;
            ba_reg <= 16'd16000;
            pa_reg <= 16'd20000;
        end
        else if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_WARNING_BUFFER:   wb_reg <= cfg_data[11:0];
                REG_WARNING_POWER:    wp_reg <= cfg_data;
                REG_POWER_CEILING:    pc_reg <= cfg_data;
                REG_BUFFER_ALLOWANCE: ba_reg <= cfg_data;
                REG_POWER_ALLOWANCE:  pa_reg <= cfg_data;
                default: ;            // unknown index: dropped
            endcase
        end
    end

    // ---------------- flow control ----------------
    // Global advance: everything moves unless the skid word is parked.
    logic          adv;
    logic          accept;
    logic [NV-1:0] valid_reg;
    logic          skid_full_reg;

    assign adv          = !skid_full_reg;
    assign sample_ready = adv;
    assign accept       = sample_valid && sample_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[NV-2:0], accept};
    end

    // ---------------- p0: input capture ----------------
    in_word_t in_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            in_reg <= sample;
    end

    // ---------------- p1: magnitudes, sum, branch select ----------------
    logic [FIELDS-1:0][15:0] raw;
    alw_side_t   side1_next, side1_reg;
    logic [15:0] x_next, y_next, d_next;
    logic [15:0] x_reg, y_reg, d1_reg;
    logic [15:0] b_floor;

    assign raw[0] = in_reg.current_0;
    assign raw[1] = in_reg.current_1;
    assign raw[2] = in_reg.current_2;
    assign raw[3] = in_reg.current_3;
    assign b_floor = (in_reg.energy_buffer > BUFFER_FLOOR) ?
                     in_reg.energy_buffer : BUFFER_FLOOR;

    always_comb
    begin
        side1_next.en  = in_reg.enable;
        side1_next.sum = '0;
        for (int i = 0; i < FIELDS; i++)
        begin
            side1_next.neg[i] = raw[i][15];
            // -32768 comes out as 16'h8000, magnitude 32768
            side1_next.mag[i] = raw[i][15] ? (~raw[i] + 16'd1) : raw[i];
            if (i < LANES)
                side1_next.sum = side1_next.sum + {2'b00, side1_next.mag[i]};
        end

        // constant-allowance cases run the divider as q = 0 / 1
        x_next = '0;
        y_next = '0;
        d_next = 16'd1;
        side1_next.base = '0;
        if (in_reg.energy_buffer < {4'd0, wb_reg})
        begin
            x_next = ba_reg;
            y_next = b_floor;
            d_next = {4'd0, wb_reg};
        end
        else if (in_reg.power > wp_reg)
        begin
            side1_next.base = {1'b0, ba_reg};
            if (in_reg.power < pc_reg)
            begin
                x_next = pa_reg;
                y_next = pc_reg - in_reg.power;
                d_next = pc_reg - wp_reg;
            end
        end
        else
        begin
            side1_next.base = {1'b0, ba_reg} + {1'b0, pa_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side1_reg <= side1_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            d1_reg    <= d_next;
        end
    end

    // ---------------- p2: allowance numerator ----------------
    logic [ALW_W-1:0] num_reg;
    logic [15:0]      d2_reg;
    alw_side_t        side2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg   <= x_reg * y_reg;
            d2_reg    <= d1_reg;
            side2_reg <= side1_reg;
        end
    end

    // ---------------- allowance divider ----------------
    logic [ALW_W-1:0]  alw_q;
    logic [ALW_SW-1:0] alw_side_raw;
    alw_side_t         alw_side;

    plim_div #(
        .NUM_W  (ALW_W),
        .DEN_W  (16),
        .SIDE_W (ALW_SW)
    ) u_alw_div (
        .clk      (clk),
        .adv      (adv),
        .num      (num_reg),
        .den      (d2_reg),
        .side_in  (side2_reg),
        .quo      (alw_q),
        .side_out (alw_side_raw)
    );

    assign alw_side = alw_side_t'(alw_side_raw);

    // ---------------- p35: saturate allowance, decide scaling ----------------
    logic [ALW_W:0] a_full;
    logic [17:0]    allow_next, allow_reg;
    logic           scale_reg;
    alw_side_t      side35_reg;

    assign a_full     = {1'b0, alw_q} + {{(ALW_W-16){1'b0}}, alw_side.base};
    assign allow_next = (a_full > {{(ALW_W-17){1'b0}}, ALLOW_MAX}) ?
                        ALLOW_MAX : a_full[17:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            allow_reg  <= allow_next;
            scale_reg  <= alw_side.en && (alw_side.sum > allow_next);
            side35_reg <= alw_side;
        end
    end

    // ---------------- p36 + lanes: per-motor scaling ----------------
    logic [FIELDS-1:0][15:0] lim;

    for (genvar i = 0; i < FIELDS; i++) begin : g_lane
        if (i < LANES) begin : g_on
            logic [LANE_W-1:0]  prod_reg;
            logic [17:0]        sum_reg;
            lane_side_t         ls_reg;
            logic [LANE_W-1:0]  lq;
            logic [LANE_SW-1:0] lside_raw;
            lane_side_t         lside;
            logic [15:0]        m;

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    prod_reg     <= side35_reg.mag[i] * allow_reg;
                    sum_reg      <= side35_reg.sum;
                    ls_reg.neg   <= side35_reg.neg[i];
                    ls_reg.scale <= scale_reg;
                    ls_reg.mag   <= side35_reg.mag[i];
                end
            end

            plim_div #(
                .NUM_W  (LANE_W),
                .DEN_W  (18),
                .SIDE_W (LANE_SW)
            ) u_lane_div (
                .clk      (clk),
                .adv      (adv),
                .num      (prod_reg),
                .den      (sum_reg),
                .side_in  (ls_reg),
                .quo      (lq),
                .side_out (lside_raw)
            );

            // quotient < magnitude when scaling, so 16 bits hold it
            assign lside  = lane_side_t'(lside_raw);
            assign m      = lside.scale ? lq[15:0] : lside.mag;
            assign lim[i] = lside.neg ? (~m + 16'd1) : m;
        end else begin : g_off
            assign lim[i] = '0;
        end
    end

    // ---------------- merge: output register with skid ----------------
    out_word_t word;
    out_word_t out_reg, skid_reg;
    logic      out_valid_reg;
    logic      push;

    assign word.limited_0 = lim[0];
    assign word.limited_1 = lim[1];
    assign word.limited_2 = lim[2];
    assign word.limited_3 = lim[3];
    assign push = adv && valid_reg[NV-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (!out_valid_reg || result_ready)
        begin
            if (skid_full_reg)
            begin
                out_valid_reg <= 1'b1;
                skid_full_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result_ready)
            out_reg <= skid_full_reg ? skid_reg : word;
        else if (push)
            skid_reg <= word;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // ---------------- checks ----------------
    // a parked result stays put
    `PLIM_ASSERT_NEXT(a_out_hold, result_valid && !result_ready, result_valid && $stable(result))
    // skid is only used behind an occupied output register
    `PLIM_ASSERT_IMPLY(a_skid_order, skid_full_reg, out_valid_reg)

endmodule
`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the motor current power limiter. A directed table comes first, then
// random samples run through several register settings and idling phases.
// Every result word is compared with the oldest prediction waiting in a queue.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    import plim_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DEPTH = 72;      // sample to result
    localparam longint CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_ready;
    in_word_t    sample;
    logic        result_valid;
    logic        result_ready;
    out_word_t   result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    motor_current_power_limiter #(.MOTORS(4)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Local copy of the limiter registers
    logic [11:0] warn_buf;
    logic [15:0] warn_pwr;
    logic [15:0] pwr_ceil;
    logic [15:0] buf_allow;
    logic [15:0] pwr_allow;

    out_word_t limited_q[$];     // predicted result words, oldest first
    int        error_count = 0;
    longint    cycle_count = 0;
    int        send_idle_pct;    // chance in percent of a gap before a word
    int        recv_stall_pct;   // chance in percent of holding result_ready low

    // Total current allowance, saturated at 18 bits
    function automatic logic [17:0] current_allowance(logic [15:0] pwr, logic [15:0] ebuf);
        logic [63:0] a;
        logic [63:0] b;
        if ({4'd0, warn_buf} > ebuf) begin
            b = (ebuf > BUFFER_FLOOR) ? 64'(ebuf) : 64'(BUFFER_FLOOR);
            a = (64'(buf_allow) * b) / 64'(warn_buf);
        end
        else if (pwr > warn_pwr) begin
            if (pwr < pwr_ceil)
                a = 64'(buf_allow) + (64'(pwr_allow) * 64'(pwr_ceil - pwr))
                    / 64'(pwr_ceil - warn_pwr);
            else
                a = 64'(buf_allow);
        end
        else begin
            a = 64'(buf_allow) + 64'(pwr_allow);
        end
        return (a > 64'(ALLOW_MAX)) ? ALLOW_MAX : a[17:0];
    endfunction

    // Limited currents for one sample word
    function automatic out_word_t limit_currents(in_word_t w);
        logic [15:0] raw[4];
        logic [16:0] mag[4];
        logic [17:0] total;
        logic [17:0] allow;
        logic [63:0] m;
        logic [15:0] res[4];
        out_word_t   o;
        raw[0] = w.current_0;
        raw[1] = w.current_1;
        raw[2] = w.current_2;
        raw[3] = w.current_3;
        total = '0;
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = raw[i][15] ? (17'h10000 - 17'(raw[i])) : 17'(raw[i]);
            total += 18'(mag[i]);
        end
        allow = current_allowance(w.power, w.energy_buffer);
        for (int i = 0; i < 4; i++)
        begin
            m = 64'(mag[i]);
            if (w.enable && total > allow)
                m = (m * 64'(allow)) / 64'(total);
            res[i] = raw[i][15] ? 16'(17'h10000 - 17'(m)) : m[15:0];
        end
        o.limited_0 = res[0];
        o.limited_1 = res[1];
        o.limited_2 = res[2];
        o.limited_3 = res[3];
        return o;
    endfunction

    // Leaves cfg_valid high so writes can follow back to back
    task automatic write_reg(reg_index_t idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        case (idx)
            REG_WARNING_BUFFER:   warn_buf  = data[11:0];
            REG_WARNING_POWER:    warn_pwr  = data;
            REG_POWER_CEILING:    pwr_ceil  = data;
            REG_BUFFER_ALLOWANCE: buf_allow = data;
            REG_POWER_ALLOWANCE:  pwr_allow = data;
            default: ;
        endcase
    endtask

    task automatic set_limits(logic [11:0] wb, logic [15:0] wp, logic [15:0] pc,
                              logic [15:0] ba, logic [15:0] pa);
        write_reg(REG_WARNING_BUFFER, {4'd0, wb});
        write_reg(REG_WARNING_POWER, wp);
        write_reg(REG_POWER_CEILING, pc);
        write_reg(REG_BUFFER_ALLOWANCE, ba);
        write_reg(REG_POWER_ALLOWANCE, pa);
        cfg_valid <= 1'b0;
    endtask

    // Drive one sample word; prediction is queued on acceptance. Valid stays
    // high between back-to-back words, never dropped and raised in one step.
    task automatic send_word(in_word_t w);
        if ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= w;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        limited_q.push_back(limit_currents(w));
        @(negedge clk);
    endtask

    task automatic stop_sending();
        sample_valid <= 1'b0;
    endtask

    // Let the pipeline empty before touching registers
    task automatic drain();
        stop_sending();
        while (limited_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH / 8) @(negedge clk);
    endtask

    function automatic logic [15:0] rand_current();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 16'h8000;    // full negative
        if (r < 20)
            return 16'(int'($urandom_range(0, 2)) * 16384 - 16384);
        if (r < 60)
            return 16'(int'($urandom_range(0, 32768)) - 16384);
        return 16'($urandom);
    endfunction

    function automatic in_word_t rand_sample();
        in_word_t w;
        w.enable        = ($urandom_range(99) < 85);
        w.power         = ($urandom_range(1)) ? 16'($urandom_range(0, 2000)) : 16'($urandom);
        w.energy_buffer = ($urandom_range(1)) ? 16'($urandom_range(0, 1500)) : 16'($urandom);
        w.current_0     = rand_current();
        w.current_1     = rand_current();
        w.current_2     = rand_current();
        w.current_3     = rand_current();
        return w;
    endfunction

    // Directed rows: a word, and where it is obvious, the result it must give
    typedef struct {
        in_word_t  w;
        logic      known;
        out_word_t o;
    } row_t;

    row_t rows[$];

    function automatic row_t mk(logic en, logic [15:0] p, logic [15:0] b,
                                logic [15:0] c0, logic [15:0] c1,
                                logic [15:0] c2, logic [15:0] c3,
                                logic known, out_word_t o);
        row_t r;
        r.w = '{en, p, b, c0, c1, c2, c3};
        r.known = known;
        r.o = o;
        return r;
    endfunction

    // Clock and cycle guard
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("motor_current_power_limiter verification failed");
            $finish;
        end
    end

    // Result side: random stalls and compare with the oldest prediction
    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && result_valid && result_ready)
        begin
            if (limited_q.size() == 0)
            begin
                $error("result word with nothing expected: %h", result);
                error_count++;
            end
            else
            begin
                e = limited_q.pop_front();
                if (result.limited_0 !== e.limited_0)
                begin
                    $error("limited_0 expected %0d got %0d", e.limited_0, result.limited_0);
                    error_count++;
                end
                if (result.limited_1 !== e.limited_1)
                begin
                    $error("limited_1 expected %0d got %0d", e.limited_1, result.limited_1);
                    error_count++;
                end
                if (result.limited_2 !== e.limited_2)
                begin
                    $error("limited_2 expected %0d got %0d", e.limited_2, result.limited_2);
                    error_count++;
                end
                if (result.limited_3 !== e.limited_3)
                begin
                    $error("limited_3 expected %0d got %0d", e.limited_3, result.limited_3);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int n;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_WARNING_BUFFER;
        cfg_data     = '0;
        warn_buf  = 12'd960;
        warn_pwr  = 16'd640;
        pwr_ceil  = 16'd1280;
        buf_allow = 16'd16000;
        pwr_allow = 16'd20000;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset registers: allowance 36000 with a full buffer and low power
        rows.push_back(mk(1, 0, 2000, 16'd1000, -16'sd2000, 16'd3000, -16'sd4000,
                          1, '{16'd1000, -16'sd2000, 16'd3000, -16'sd4000}));
        // Disabled: passes through even over the allowance
        rows.push_back(mk(0, 16'hFFFF, 0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                          1, '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}));
        // Power at the ceiling: allowance 16000, sum 32000 halves the currents
        rows.push_back(mk(1, 1280, 2000, 16'd8000, -16'sd8000, 16'd8000, -16'sd8000,
                          1, '{16'd4000, -16'sd4000, 16'd4000, -16'sd4000}));
        // Zero currents
        rows.push_back(mk(1, 16'hFFFF, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0}));
        // Taper region, buffer below warning, buffer below 5 J, extreme negatives
        rows.push_back(mk(1, 960, 2000, 16'd16384, 16'd16384, -16'sd16384, 16'd100, 0, '0));
        rows.push_back(mk(1, 641, 960, 16'd16384, 16'd16384, 16'd16384, 16'd16384, 0, '0));
        rows.push_back(mk(1, 1279, 959, -16'sd16384, 16'd5, -16'sd7, 16'd30000, 0, '0));
        rows.push_back(mk(1, 0, 500, 16'd9000, 16'd9000, 16'd9000, 16'd9000, 0, '0));
        rows.push_back(mk(1, 0, 80, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, '0));
        rows.push_back(mk(1, 0, 0, 16'd1, -16'sd1, 16'd1, -16'sd1, 0, '0));
        rows.push_back(mk(1, 0, 81, 16'd1000, 16'd1000, -16'sd1000, 16'd1000, 0, '0));
        rows.push_back(mk(1, 640, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, '0));

        foreach (rows[i])
        begin
            send_word(rows[i].w);
            if (rows[i].known)
                limited_q[$] = rows[i].o;   // typed-in value replaces the prediction
        end
        drain();

        // Random part over register settings and idling phases
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_limits(12'd960, 16'd640, 16'd1280, 16'd16000, 16'd20000);
                1: set_limits(12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: set_limits(12'd1, 16'd0, 16'd1, 16'd0, 16'd0);
                3: set_limits(12'd40, 16'd100, 16'd200, 16'hFFFF, 16'hFFFF);
                4: set_limits(12'd500, 16'd1000, 16'd500, 16'd3000, 16'd9000);
                5: set_limits(12'd2000, 16'd300, 16'd301, 16'd20000, 16'd40000);
                default: set_limits(12'($urandom_range(1, 4095)), 16'($urandom_range(0, 1500)),
                                    16'($urandom_range(0, 3000)), 16'($urandom),
                                    16'($urandom));
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            n = 85;
            for (int k = 0; k < n; k++)
            begin
                send_word(rand_sample());
                if (k == n / 2)
                begin
                    // hold off until everything in flight has come back
                    stop_sending();
                    while (limited_q.size() != 0)
                        @(negedge clk);
                end
            end
            drain();
        end

        recv_stall_pct = 0;
        repeat (PIPE_DEPTH * 2) @(negedge clk);
        if (error_count == 0 && limited_q.size() == 0)
            $display("motor_current_power_limiter verification clean");
        else
            $display("motor_current_power_limiter verification failed");
        $finish;
    end

endmodule
`default_nettype wire
